// ===== rtl/sepc_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo easing position controller package
// Shared types, command codes and fixed constants for the controller blocks.
// ----------------------------------------------------------------------------
package sepc_pkg;

    // Angles are unsigned Q8.8 degrees.
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned IN_ANGLE_W = 18;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned CH_W = 4;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ANGLE_W-1:0] FULL_ANGLE = 16'd46080;
    localparam logic [ANGLE_W-1:0] MID_ANGLE = 16'd23040;
    localparam logic [PULSE_W-1:0] PULSE_SAT = 12'd4095;

    // Division by 46080 = 1024 * 45: shift by 10, then multiply by the
    // rounded-up reciprocal of 45 scaled by 2^24. Exact for 18-bit dividends.
    localparam int unsigned DIV_SHIFT = 10;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam logic [18:0] RECIP_45 = 19'd372828;

    // Configuration reset values.
    localparam logic [15:0] EASE_RST = 16'd7864;
    localparam logic [15:0] SNAP_RST = 16'd26;
    localparam logic [PULSE_W-1:0] PMIN_RST = 12'd500;
    localparam logic [PULSE_W-1:0] PMAX_RST = 12'd2500;
    localparam logic [CH_W-1:0] MASTER_RST = 4'd1;
    localparam logic [CH_W-1:0] SLAVE_RST = 4'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EASE   = 3'd0,
        CFG_SNAP   = 3'd1,
        CFG_PMIN   = 3'd2,
        CFG_PMAX   = 3'd3,
        CFG_MASTER = 3'd4,
        CFG_SLAVE  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SET  = 2'd1,
        KIND_CAL  = 2'd2,
        KIND_BAD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CH   = 2'd1,
        ST_BAD_KIND = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0]        ease;
        logic [15:0]        snap;
        logic [PULSE_W-1:0] pmin;
        logic [PULSE_W-1:0] pmax;
        logic [CH_W-1:0]    master;
        logic [CH_W-1:0]    slave;
    } cfg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_STEP,
        DP_MOVE,
        DP_PMUL,
        DP_PDIV,
        DP_SET,
        DP_MIRROR,
        DP_CAL_LO,
        DP_CAL_HI,
        DP_EMIT_TICK,
        DP_EMIT_SET,
        DP_EMIT_CAL,
        DP_EMIT_BADCH,
        DP_EMIT_BADKIND
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [CH_W-1:0] idx;
        logic            last;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ch_ok;
        logic  mirror_go;
        logic  out_free;
    } dp_stat_t;

endpackage

// ===== rtl/sepc_cfg.sv =====
// ----------------------------------------------------------------------------
// Servo easing configuration registers
// Holds the easing, snap, pulse range and mirror settings.
// ----------------------------------------------------------------------------
module sepc_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sepc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sepc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output sepc_pkg::cfg_t                    cfg
);
    import sepc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ease   <= EASE_RST;
            cfg_reg.snap   <= SNAP_RST;
            cfg_reg.pmin   <= PMIN_RST;
            cfg_reg.pmax   <= PMAX_RST;
            cfg_reg.master <= MASTER_RST;
            cfg_reg.slave  <= SLAVE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_EASE:   cfg_reg.ease   <= cfg_wdata;
                CFG_SNAP:   cfg_reg.snap   <= cfg_wdata;
                CFG_PMIN:   cfg_reg.pmin   <= cfg_wdata[PULSE_W-1:0];
                CFG_PMAX:   cfg_reg.pmax   <= cfg_wdata[PULSE_W-1:0];
                CFG_MASTER: cfg_reg.master <= cfg_wdata[CH_W-1:0];
                CFG_SLAVE:  cfg_reg.slave  <= cfg_wdata[CH_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/sepc_dpath.sv =====
// ----------------------------------------------------------------------------
// Servo easing datapath
// Channel state, easing arithmetic, pulse scaling and the result register.
// ----------------------------------------------------------------------------
module sepc_dpath
#(
    parameter int CHANNELS = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sepc_pkg::cfg_t       cfg,
    input  sepc_pkg::dp_cmd_t    cmd,
    output sepc_pkg::dp_stat_t   stat,
    input  logic [39:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);
    import sepc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W:0] CH_CNT = (CH_W+1)'(CHANNELS);

    // Per-channel state.
    logic [ANGLE_W-1:0] cur_arr_reg [CHANNELS];
    logic [ANGLE_W-1:0] tgt_arr_reg [CHANNELS];
    logic [ANGLE_W-1:0] lmin_arr_reg [CHANNELS];
    logic [ANGLE_W-1:0] lmax_arr_reg [CHANNELS];

    // Captured input item.
    kind_t                  kind_reg;
    logic [CH_W-1:0]        ch_reg;
    logic [IN_ANGLE_W-1:0]  a_reg;
    logic [IN_ANGLE_W-1:0]  b_reg;

    // Working registers.
    logic [ANGLE_W-1:0]     tgt_reg;
    logic [ANGLE_W-1:0]     cur_reg;
    logic [ANGLE_W-1:0]     mag_reg;
    logic                   neg_reg;
    logic                   snap_reg;
    logic [ANGLE_W-1:0]     step_reg;
    logic signed [12:0]     span_reg;
    logic signed [29:0]     prod_reg;
    logic [PULSE_W-1:0]     qmag_reg;
    logic                   qneg_reg;
    logic [ANGLE_W-1:0]     val_a_reg;
    logic [ANGLE_W-1:0]     val_b_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [CH_W-1:0]        out_ch_reg;
    logic [PULSE_W-1:0]     out_pulse_reg;
    logic [ANGLE_W-1:0]     out_angle_reg;
    logic [ANGLE_W-1:0]     out_lmax_reg;
    status_t                out_status_reg;
    logic                   out_last_reg;

    logic [IDX_W-1:0]       rd_idx;
    logic [ANGLE_W-1:0]     cur_rd;
    logic [ANGLE_W-1:0]     tgt_rd;
    logic [ANGLE_W-1:0]     lmin_rd;
    logic [ANGLE_W-1:0]     lmax_rd;

    logic signed [16:0]     diff;
    logic [ANGLE_W-1:0]     mag;
    logic [31:0]            ease_sum;
    logic [ANGLE_W-1:0]     cur_next;
    logic [29:0]            prod_abs;
    logic [36:0]            recip_prod;
    logic signed [13:0]     pulse_sum;
    logic [PULSE_W-1:0]     pulse_sat;

    logic signed [18:0]     a_ext;
    logic signed [18:0]     b_ext;
    logic signed [18:0]     lmin_ext;
    logic signed [18:0]     lmax_ext;
    logic signed [18:0]     full_ext;
    logic signed [18:0]     lo_ext;
    logic [ANGLE_W-1:0]     set_t;
    logic [ANGLE_W-1:0]     mir_in;
    logic [ANGLE_W-1:0]     mir_t;
    logic [ANGLE_W-1:0]     cal_lo;
    logic [ANGLE_W-1:0]     cal_hi;
    logic                   emit;
    logic                   out_free;

    // One read address for all channel arrays per cycle.
    always_comb
    begin
        unique case (cmd.op)
            DP_LOAD, DP_MOVE: rd_idx = cmd.idx[IDX_W-1:0];
            DP_MIRROR:        rd_idx = cfg.slave[IDX_W-1:0];
            default:          rd_idx = ch_reg[IDX_W-1:0];
        endcase
    end

    assign cur_rd  = cur_arr_reg[rd_idx];
    assign tgt_rd  = tgt_arr_reg[rd_idx];
    assign lmin_rd = lmin_arr_reg[rd_idx];
    assign lmax_rd = lmax_arr_reg[rd_idx];

    // Easing arithmetic.
    assign diff     = $signed({1'b0, tgt_rd}) - $signed({1'b0, cur_rd});
    assign mag      = diff[16] ? 16'(-diff) : diff[15:0];
    assign ease_sum = (32'(mag_reg) * 32'(cfg.ease)) + 32'd32768;

    always_comb
    begin
        if (snap_reg)
            cur_next = tgt_reg;
        else if (neg_reg)
            cur_next = cur_reg - step_reg;
        else
            cur_next = cur_reg + step_reg;
    end

    // Pulse scaling: divide the magnitude of the product by 46080.
    assign prod_abs   = prod_reg[29] ? 30'(-prod_reg) : 30'(prod_reg);
    assign recip_prod = 37'(prod_abs[DIV_SHIFT+17:DIV_SHIFT]) * 37'(RECIP_45);

    assign pulse_sum = $signed({2'b00, cfg.pmin})
                     + (qneg_reg ? -$signed({2'b00, qmag_reg})
                                 :  $signed({2'b00, qmag_reg}));

    always_comb
    begin
        if (pulse_sum < 0)
            pulse_sat = '0;
        else if (pulse_sum > $signed({2'b00, PULSE_SAT}))
            pulse_sat = PULSE_SAT;
        else
            pulse_sat = pulse_sum[PULSE_W-1:0];
    end

    // Clamps for set and calibrate.
    assign a_ext    = {a_reg[IN_ANGLE_W-1], a_reg};
    assign b_ext    = {b_reg[IN_ANGLE_W-1], b_reg};
    assign lmin_ext = $signed({3'b000, lmin_rd});
    assign lmax_ext = $signed({3'b000, lmax_rd});
    assign full_ext = $signed({3'b000, FULL_ANGLE});
    assign lo_ext   = $signed({3'b000, val_a_reg});

    always_comb
    begin
        if (a_ext < lmin_ext)
            set_t = lmin_rd;
        else if (a_ext > lmax_ext)
            set_t = lmax_rd;
        else
            set_t = a_reg[ANGLE_W-1:0];
    end

    assign mir_in = FULL_ANGLE - val_a_reg;

    always_comb
    begin
        if (mir_in < lmin_rd)
            mir_t = lmin_rd;
        else if (mir_in > lmax_rd)
            mir_t = lmax_rd;
        else
            mir_t = mir_in;
    end

    always_comb
    begin
        if (a_ext < 0)
            cal_lo = '0;
        else if (a_ext > full_ext)
            cal_lo = FULL_ANGLE;
        else
            cal_lo = a_reg[ANGLE_W-1:0];
    end

    always_comb
    begin
        if (b_ext < lo_ext)
            cal_hi = val_a_reg;
        else if (b_ext > full_ext)
            cal_hi = FULL_ANGLE;
        else
            cal_hi = b_reg[ANGLE_W-1:0];
    end

    // Channel state arrays.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_arr_reg[i]  <= MID_ANGLE;
                tgt_arr_reg[i]  <= MID_ANGLE;
                lmin_arr_reg[i] <= '0;
                lmax_arr_reg[i] <= FULL_ANGLE;
            end
        end
        else
        begin
            unique case (cmd.op)
                DP_MOVE:   cur_arr_reg[rd_idx] <= cur_next;
                DP_SET:    tgt_arr_reg[rd_idx] <= set_t;
                DP_MIRROR: tgt_arr_reg[rd_idx] <= mir_t;
                DP_CAL_HI:
                begin
                    lmin_arr_reg[rd_idx] <= val_a_reg;
                    lmax_arr_reg[rd_idx] <= cal_hi;
                end
                default: ;
            endcase
        end
    end

    // Working registers need no reset.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                kind_reg <= kind_t'(s_tuser);
                ch_reg   <= s_tdata[3:0];
                a_reg    <= s_tdata[21:4];
                b_reg    <= s_tdata[39:22];
            end
            DP_LOAD:
            begin
                tgt_reg  <= tgt_rd;
                cur_reg  <= cur_rd;
                mag_reg  <= mag;
                neg_reg  <= diff[16];
                snap_reg <= (mag < cfg.snap);
                span_reg <= $signed({1'b0, cfg.pmax}) - $signed({1'b0, cfg.pmin});
            end
            DP_STEP:   step_reg <= ease_sum[31:16];
            DP_MOVE:   cur_reg  <= cur_next;
            DP_PMUL:   prod_reg <= 30'($signed({1'b0, cur_reg}) * span_reg);
            DP_PDIV:
            begin
                qmag_reg <= recip_prod[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
                qneg_reg <= prod_reg[29];
            end
            DP_SET:    val_a_reg <= set_t;
            DP_CAL_LO: val_a_reg <= cal_lo;
            DP_CAL_HI: val_b_reg <= cal_hi;
            default: ;
        endcase
    end

    // Result register: loads on an emit command, drains on handshake.
    assign out_free = !out_valid_reg || m_tready;
    assign emit = (cmd.op == DP_EMIT_TICK) || (cmd.op == DP_EMIT_SET)
               || (cmd.op == DP_EMIT_CAL) || (cmd.op == DP_EMIT_BADCH)
               || (cmd.op == DP_EMIT_BADKIND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_EMIT_TICK:
            begin
                out_ch_reg     <= cmd.idx;
                out_pulse_reg  <= pulse_sat;
                out_angle_reg  <= cur_reg;
                out_lmax_reg   <= '0;
                out_status_reg <= ST_OK;
                out_last_reg   <= cmd.last;
            end
            DP_EMIT_SET:
            begin
                out_ch_reg     <= ch_reg;
                out_pulse_reg  <= '0;
                out_angle_reg  <= val_a_reg;
                out_lmax_reg   <= '0;
                out_status_reg <= ST_OK;
                out_last_reg   <= 1'b1;
            end
            DP_EMIT_CAL:
            begin
                out_ch_reg     <= ch_reg;
                out_pulse_reg  <= '0;
                out_angle_reg  <= val_a_reg;
                out_lmax_reg   <= val_b_reg;
                out_status_reg <= ST_OK;
                out_last_reg   <= 1'b1;
            end
            DP_EMIT_BADCH, DP_EMIT_BADKIND:
            begin
                out_ch_reg     <= ch_reg;
                out_pulse_reg  <= '0;
                out_angle_reg  <= '0;
                out_lmax_reg   <= '0;
                out_status_reg <= (cmd.op == DP_EMIT_BADCH) ? ST_BAD_CH : ST_BAD_KIND;
                out_last_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_lmax_reg, out_angle_reg, out_pulse_reg, out_ch_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign stat.kind      = kind_reg;
    assign stat.ch_ok     = ({1'b0, ch_reg} < CH_CNT);
    assign stat.mirror_go = (ch_reg == cfg.master) && ({1'b0, cfg.slave} < CH_CNT);
    assign stat.out_free  = out_free;

endmodule

// ===== rtl/sepc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Servo easing controller
// Sequences each item through the datapath, one channel at a time on ticks.
// ----------------------------------------------------------------------------
module sepc_ctrl
#(
    parameter int CHANNELS = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  sepc_pkg::dp_stat_t   stat,
    output sepc_pkg::dp_cmd_t    cmd
);
    import sepc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_T_LOAD,
        S_T_STEP,
        S_T_MOVE,
        S_T_PMUL,
        S_T_PDIV,
        S_T_EMIT,
        S_SET,
        S_MIRROR,
        S_SET_EMIT,
        S_CAL_LO,
        S_CAL_HI,
        S_CAL_EMIT,
        S_ERR_CH,
        S_ERR_KIND
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                        state_reg <= S_DECODE;
                S_DECODE:
                begin
                    idx_reg <= '0;
                    priority if (stat.kind == KIND_BAD)
                        state_reg <= S_ERR_KIND;
                    else if (stat.kind == KIND_TICK)
                        state_reg <= S_T_LOAD;
                    else if (!stat.ch_ok)
                        state_reg <= S_ERR_CH;
                    else if (stat.kind == KIND_SET)
                        state_reg <= S_SET;
                    else
                        state_reg <= S_CAL_LO;
                end
                S_T_LOAD: state_reg <= S_T_STEP;
                S_T_STEP: state_reg <= S_T_MOVE;
                S_T_MOVE: state_reg <= S_T_PMUL;
                S_T_PMUL: state_reg <= S_T_PDIV;
                S_T_PDIV: state_reg <= S_T_EMIT;
                S_T_EMIT:
                    if (stat.out_free)
                    begin
                        if (idx_reg == IDX_LAST)
                            state_reg <= S_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_T_LOAD;
                        end
                    end
                S_SET:    state_reg <= stat.mirror_go ? S_MIRROR : S_SET_EMIT;
                S_MIRROR: state_reg <= S_SET_EMIT;
                S_CAL_LO: state_reg <= S_CAL_HI;
                S_CAL_HI: state_reg <= S_CAL_EMIT;
                S_SET_EMIT, S_CAL_EMIT, S_ERR_CH, S_ERR_KIND:
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd.idx  = CH_W'(idx_reg);
        cmd.last = (idx_reg == IDX_LAST);
        unique case (state_reg)
            S_IDLE:     cmd.op = s_tvalid ? DP_CAPTURE : DP_NOP;
            S_T_LOAD:   cmd.op = DP_LOAD;
            S_T_STEP:   cmd.op = DP_STEP;
            S_T_MOVE:   cmd.op = DP_MOVE;
            S_T_PMUL:   cmd.op = DP_PMUL;
            S_T_PDIV:   cmd.op = DP_PDIV;
            S_T_EMIT:   cmd.op = stat.out_free ? DP_EMIT_TICK : DP_NOP;
            S_SET:      cmd.op = DP_SET;
            S_MIRROR:   cmd.op = DP_MIRROR;
            S_SET_EMIT: cmd.op = stat.out_free ? DP_EMIT_SET : DP_NOP;
            S_CAL_LO:   cmd.op = DP_CAL_LO;
            S_CAL_HI:   cmd.op = DP_CAL_HI;
            S_CAL_EMIT: cmd.op = stat.out_free ? DP_EMIT_CAL : DP_NOP;
            S_ERR_CH:   cmd.op = stat.out_free ? DP_EMIT_BADCH : DP_NOP;
            S_ERR_KIND: cmd.op = stat.out_free ? DP_EMIT_BADKIND : DP_NOP;
            default:    cmd.op = DP_NOP;
        endcase
    end

endmodule

// ===== rtl/servo_easing_position_controller_core.sv =====
// A tick: capture, decode, then per channel load, step, move, multiply, divide and emit.
// Set target: capture, decode, set, mirror if it applies, emit. Calibrate: capture,
// decode, low limit, high limit, emit. Throughput: one input item at a time; the next
// is taken once the last result is queued; all channels share the easing and pulse scaler.
// Reset: asynchronous, active low; all channels return to 90 degrees with full limits.
// ----------------------------------------------------------------------------
// Servo easing position controller core
// Per-channel target tracking with exponential easing and pulse-width output.
// ----------------------------------------------------------------------------
module servo_easing_position_controller_core
#(
    parameter int CHANNELS = 7
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input items.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [39:0]                           s_tdata,  // channel, angle_in, angle_max_in
    input  logic [1:0]                            s_tuser,  // kind
    // Result items.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [47:0]                           m_tdata,  // channel_out, pulse_us,
                                                            // angle_out, limit_max_out
    output logic [1:0]                            m_tuser,  // status
    output logic                                  m_tlast,
    // Configuration writes.
    input  logic                                  cfg_we,
    input  logic [sepc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [sepc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import sepc_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The configuration block holds the six settings; the user must change them only while the core
    // is idle, as the core has no guard of its own, and the datapath reads them directly.
    sepc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The controller walks an item through its steps. On a tick it visits
    // every channel in order: load, ease step, move, pulse multiply, pulse
    // divide, emit. The emit step waits while the result register is full and not being taken.
    sepc_ctrl #(.CHANNELS(CHANNELS)) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the channel state and the result register, which
    // decouples the output handshake from the sequencing.
    sepc_dpath #(.CHANNELS(CHANNELS)) u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The core works on one item at a time: after acceptance it is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in progress");

    // Error results are single, final and carry no pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata[15:4] == '0)))
        else $error("error result is not a single zero-pulse item");

    // Reported angles never exceed 180 degrees.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:16] <= FULL_ANGLE))
        else $error("reported angle beyond 180 degrees");

endmodule
